>>> rtl/crst_pkg.sv
package crst_pkg;

	// Sizing of the row, the tree and the removal history.
	localparam int MAX_POSITIONS = 4096;
	localparam int HISTORY_DEPTH = 1024;

	// Field widths of the channels.
	localparam int POS_W = 13;
	localparam int RUN_W = $clog2(MAX_POSITIONS + 1);

	// Tree geometry: leaves sit at most MAX_LEVELS below the root at node 1.
	localparam int MAX_LEVELS = $clog2(MAX_POSITIONS);
	localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int LVC_W = $clog2(MAX_LEVELS + 1);
	localparam int NODE_AW = MAX_LEVELS + 1;
	localparam int TREE_NODES = 2 ** NODE_AW;

	// History stack addressing.
	localparam int HIST_AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [RUN_W-1:0] run_t;
	typedef logic [NODE_AW-1:0] node_addr_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// One tree node. A fresh node has not been written since the last clear
	// and stands for a fully intact range.
	typedef struct packed {
		logic fresh;
		run_t longest;
		run_t prefix;
		run_t suffix;
	} node_t;

	typedef enum logic [1:0] {
		CMD_REMOVE  = 2'd0,
		CMD_RESTORE = 2'd1,
		CMD_QUERY   = 2'd2,
		CMD_CLEAR   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK    = 2'd0,
		STS_EMPTY = 2'd1,
		STS_FULL  = 2'd2,
		STS_RANGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_POP,
		S_DOWN,
		S_UP,
		S_QROOT,
		S_QEVAL,
		S_DONE
	} state_t;

	localparam node_addr_t ROOT_NODE = NODE_AW'(1);
	localparam node_t FRESH_NODE = '{fresh: 1'b1, longest: '0, prefix: '0, suffix: '0};

	// Midpoint of a node range, as the split between its two children.
	function automatic pos_t mid(input pos_t lo, input pos_t hi);
		logic [POS_W:0] sum;
		sum = {1'b0, lo} + {1'b0, hi};
		return sum[POS_W:1];
	endfunction

	// Number of positions in the range lo..hi.
	function automatic run_t node_size(input pos_t lo, input pos_t hi);
		pos_t diff;
		diff = hi - lo;
		return RUN_W'(diff) + RUN_W'(1);
	endfunction

	// Turn a stored node into its real values, given the size of its range.
	function automatic node_t resolve(input node_t w, input run_t size);
		node_t r;
		r = w;
		if (w.fresh) begin
			r.longest = size;
			r.prefix = size;
			r.suffix = size;
		end
		r.fresh = 1'b0;
		return r;
	endfunction

endpackage

>>> rtl/crst_if.sv
// Request channel: one command with its position.
interface crst_req_if;
	import crst_pkg::*;

	logic valid;
	logic ready;
	logic [1:0] command;
	logic [POS_W-1:0] position;

	modport source (output valid, output command, output position, input ready);
	modport sink (input valid, input command, input position, output ready);
endinterface

// Result channel: one run length and status per request.
interface crst_res_if;
	import crst_pkg::*;

	logic valid;
	logic ready;
	logic [RUN_W-1:0] run_length;
	logic [1:0] status;

	modport source (output valid, output run_length, output status, input ready);
	modport sink (input valid, input run_length, input status, output ready);
endinterface

>>> rtl/crst_merge.sv
// Combines two child nodes into their parent over the range lo..hi.
module crst_merge (
	input  crst_pkg::node_t a,
	input  crst_pkg::node_t b,
	input  crst_pkg::pos_t  lo,
	input  crst_pkg::pos_t  hi,
	output crst_pkg::node_t m
);
	import crst_pkg::*;

	pos_t half;
	pos_t half_next;
	run_t left_size;
	run_t right_size;
	logic [RUN_W:0] run_join;
	run_t best;

	always_comb begin
		half = mid(lo, hi);
		half_next = half + POS_W'(1);
		left_size = node_size(lo, half);
		right_size = node_size(half_next, hi);

		// The longest run is in one child or spans the split.
		run_join = {1'b0, a.suffix} + {1'b0, b.prefix};
		best = a.longest;
		if (b.longest > best) begin
			best = b.longest;
		end
		if (run_join > {1'b0, best}) begin
			best = run_join[RUN_W-1:0];
		end

		m.fresh = 1'b0;
		m.longest = best;

		// Edge runs extend into the other child when this child is all intact.
		m.prefix = (a.prefix == left_size) ? a.prefix + b.prefix : a.prefix;
		m.suffix = (b.suffix == right_size) ? b.suffix + a.suffix : b.suffix;
	end

endmodule

>>> rtl/contiguous_run_segment_tree_top.sv
// Longest intact run tracker over a row of positions 1..used_positions.
// Requests arrive on req (command, position) and each one returns exactly one
// item on result (run_length, status), in order, with a valid/ready handshake.
// Writing cfg_wr_en with cfg_wr_data sets used_positions (0 acts as 1, values
// above the row size act as the row size) and clears the row and history.
// One request is worked at a time; req.ready is high only between requests.
// The tree has D = ceil(log2(used_positions)) levels. In a remove or restore
// the walk down reads one sibling node per cycle, and the walk back up rewrites
// one node per cycle through the shared merge unit and the single write port
// of the node memory. A query goes down one tree level per cycle on the two
// read ports. Out of range requests and restores on an empty history go
// straight to the finish state without a walk.
// A clear command, a configuration write and reset each run a clearing pass
// over all 8192 node entries, one entry per cycle, while req.ready is low;
// a clear command returns its result after the pass.
// The result register holds a finished result while the receiver stalls and
// a new request is still taken; the block waits to hand over the next result
// until the register is free.
module contiguous_run_segment_tree_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [crst_pkg::POS_W-1:0] cfg_wr_data,
	crst_req_if.sink               req,
	crst_res_if.source             result
);
	import crst_pkg::*;

	// Control state.
	state_t state_q, state_d;
	pos_t n_q;
	cnt_t cnt_q;
	node_addr_t clr_addr_q;
	logic clr_rpt_q;
	logic out_valid_q;
	logic sib_we_q;

	// Working registers of the current request.
	pos_t pos_q;
	pos_t lo_q;
	pos_t hi_q;
	node_addr_t node_q;
	logic [LVC_W-1:0] lvl_q;
	logic val_q;
	node_t cur_q;
	run_t run_q;
	status_t status_q;
	logic [LVL_W-1:0] sib_lvl_q;
	run_t out_run_q;
	status_t out_status_q;

	// Per-level record of the walk down, used on the way back up.
	pos_t lo_lv_q [MAX_LEVELS];
	pos_t hi_lv_q [MAX_LEVELS];
	logic dir_lv_q [MAX_LEVELS];
	node_t sib_lv_q [MAX_LEVELS];

	// Memories.
	node_t tree_mem [TREE_NODES];
	node_t rd_a_q;
	node_t rd_b_q;
	pos_t hist_mem [HISTORY_DEPTH];
	pos_t hist_rd_q;

	// Decoded request and shared terms.
	logic accept;
	cmd_t cmd;
	logic in_range;
	logic hist_room;
	logic out_free;
	pos_t cfg_n;
	cnt_t cnt_dec;
	logic [HIST_AW-1:0] hist_raddr;

	pos_t half;
	pos_t half_next;
	run_t size;
	run_t left_size;
	run_t right_size;
	logic leaf;
	logic dir;
	node_t leaf_word;

	// Walk back up.
	logic [LVL_W-1:0] up_k;
	pos_t up_lo;
	pos_t up_hi;
	logic up_dir;
	pos_t up_half;
	pos_t up_half_next;
	run_t sib_size;
	node_t up_sib;
	node_t mrg_a;
	node_t mrg_b;
	node_t mrg_out;

	// Query step.
	node_t qa;
	node_t qb;
	logic q_stop;
	logic q_left;
	logic q_hit_l;
	logic q_hit_r;
	logic q_done;
	run_t q_join;
	run_t q_run;
	node_addr_t q_next_node;

	// Memory controls.
	logic mem_we;
	node_addr_t mem_waddr;
	node_t mem_wdata;
	node_addr_t rd_addr_a;
	node_addr_t rd_addr_b;
	logic hist_we;

	// Request decode.
	always_comb begin
		accept = req.valid && req.ready;
		cmd = cmd_t'(req.command);
		in_range = (req.position != '0) && (req.position <= n_q);
		hist_room = cnt_q < CNT_W'(HISTORY_DEPTH);
		out_free = !out_valid_q || result.ready;
		cnt_dec = cnt_q - CNT_W'(1);
		hist_raddr = cnt_dec[HIST_AW-1:0];
	end

	// Clamp of a written row length.
	always_comb begin
		if (cfg_wr_data == '0) begin
			cfg_n = POS_W'(1);
		end else if (cfg_wr_data > POS_W'(MAX_POSITIONS)) begin
			cfg_n = POS_W'(MAX_POSITIONS);
		end else begin
			cfg_n = cfg_wr_data;
		end
	end

	// Range split of the current node.
	always_comb begin
		half = mid(lo_q, hi_q);
		half_next = half + POS_W'(1);
		size = node_size(lo_q, hi_q);
		left_size = node_size(lo_q, half);
		right_size = node_size(half_next, hi_q);
		leaf = lo_q == hi_q;
		dir = pos_q > half;
		leaf_word = '{fresh: 1'b0, longest: RUN_W'(val_q), prefix: RUN_W'(val_q),
			suffix: RUN_W'(val_q)};
	end

	// Operands of the merge on the way up.
	always_comb begin
		up_k = lvl_q[LVL_W-1:0];
		up_lo = lo_lv_q[up_k];
		up_hi = hi_lv_q[up_k];
		up_dir = dir_lv_q[up_k];
		up_half = mid(up_lo, up_hi);
		up_half_next = up_half + POS_W'(1);
		sib_size = up_dir ? node_size(up_lo, up_half) : node_size(up_half_next, up_hi);
		up_sib = resolve(sib_lv_q[up_k], sib_size);
		mrg_a = up_dir ? up_sib : cur_q;
		mrg_b = up_dir ? cur_q : up_sib;
	end

	crst_merge u_merge (
		.a  (mrg_a),
		.b  (mrg_b),
		.lo (up_lo),
		.hi (up_hi),
		.m  (mrg_out)
	);

	// One query level: stop here, answer across the split, or go down a child.
	always_comb begin
		qa = resolve(rd_a_q, left_size);
		qb = resolve(rd_b_q, right_size);
		q_stop = (cur_q.longest == '0) || (cur_q.longest == size);
		q_join = qa.suffix + qb.prefix;
		q_left = pos_q <= half;
		q_hit_l = ({1'b0, pos_q} + (POS_W + 1)'(qa.suffix)) > {1'b0, half};
		q_hit_r = {1'b0, pos_q} <= ({1'b0, half} + (POS_W + 1)'(qb.prefix));
		q_done = q_stop || (q_left ? q_hit_l : q_hit_r);
		q_run = q_stop ? cur_q.longest : q_join;
		q_next_node = {node_q[NODE_AW-2:0], !q_left};
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_addr_q == NODE_AW'(TREE_NODES - 1)) begin
					state_d = clr_rpt_q ? S_DONE : S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					unique case (cmd)
						CMD_REMOVE:  state_d = in_range ? S_DOWN : S_DONE;
						CMD_RESTORE: state_d = (cnt_q == '0) ? S_DONE : S_POP;
						CMD_QUERY:   state_d = in_range ? S_QROOT : S_DONE;
						CMD_CLEAR:   state_d = S_CLEAR;
					endcase
				end
			end
			S_POP: state_d = S_DOWN;
			S_DOWN: begin
				if (leaf) begin
					state_d = (lvl_q == '0) ? S_DONE : S_UP;
				end
			end
			S_UP: begin
				if (lvl_q == '0) begin
					state_d = S_DONE;
				end
			end
			S_QROOT: state_d = S_QEVAL;
			S_QEVAL: begin
				if (q_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
		endcase
		if (cfg_wr_en) begin
			state_d = S_CLEAR;
		end
	end

	// State outputs: handshake and memory ports.
	always_comb begin
		req.ready = 1'b0;
		mem_we = 1'b0;
		mem_waddr = node_q;
		mem_wdata = mrg_out;
		rd_addr_a = ROOT_NODE;
		rd_addr_b = ROOT_NODE;
		hist_we = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = clr_addr_q;
				mem_wdata = FRESH_NODE;
			end
			S_IDLE: begin
				req.ready = 1'b1;
				hist_we = accept && (cmd == CMD_REMOVE) && in_range && hist_room;
			end
			S_POP: begin
			end
			S_DOWN: begin
				rd_addr_a = {node_q[NODE_AW-2:0], !dir};
				if (leaf) begin
					mem_we = 1'b1;
					mem_waddr = node_q;
					mem_wdata = leaf_word;
				end
			end
			S_UP: begin
				mem_we = 1'b1;
				mem_waddr = node_q >> 1;
				mem_wdata = mrg_out;
			end
			S_QROOT: begin
				rd_addr_a = {node_q[NODE_AW-2:0], 1'b0};
				rd_addr_b = {node_q[NODE_AW-2:0], 1'b1};
			end
			S_QEVAL: begin
				rd_addr_a = {q_next_node[NODE_AW-2:0], 1'b0};
				rd_addr_b = {q_next_node[NODE_AW-2:0], 1'b1};
			end
			S_DONE: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			n_q <= POS_W'(MAX_POSITIONS);
			cnt_q <= '0;
			clr_addr_q <= '0;
			clr_rpt_q <= 1'b0;
			out_valid_q <= 1'b0;
			sib_we_q <= 1'b0;
		end else begin
			state_q <= state_d;
			sib_we_q <= (state_q == S_DOWN) && !leaf;

			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_wr_en) begin
				n_q <= cfg_n;
				cnt_q <= '0;
				clr_addr_q <= '0;
				clr_rpt_q <= 1'b0;
			end else if (accept) begin
				unique case (cmd)
					CMD_REMOVE: begin
						if (in_range && hist_room) begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
					CMD_RESTORE: begin
						if (cnt_q != '0) begin
							cnt_q <= cnt_dec;
						end
					end
					CMD_QUERY: begin
					end
					CMD_CLEAR: begin
						cnt_q <= '0;
						clr_addr_q <= '0;
						clr_rpt_q <= 1'b1;
					end
				endcase
			end else if (state_q == S_CLEAR) begin
				clr_addr_q <= clr_addr_q + NODE_AW'(1);
			end
		end
	end

	// Working registers of the walk.
	always_ff @(posedge clk) begin
		if (sib_we_q) begin
			sib_lv_q[sib_lvl_q] <= rd_a_q;
		end
		sib_lvl_q <= up_k;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					pos_q <= req.position;
					node_q <= ROOT_NODE;
					lo_q <= POS_W'(1);
					hi_q <= n_q;
					lvl_q <= '0;
					val_q <= cmd == CMD_RESTORE;
					run_q <= '0;
					unique case (cmd)
						CMD_REMOVE: begin
							if (!in_range) begin
								status_q <= STS_RANGE;
							end else if (!hist_room) begin
								status_q <= STS_FULL;
							end else begin
								status_q <= STS_OK;
							end
						end
						CMD_RESTORE: status_q <= (cnt_q == '0) ? STS_EMPTY : STS_OK;
						CMD_QUERY:   status_q <= in_range ? STS_OK : STS_RANGE;
						CMD_CLEAR:   status_q <= STS_OK;
					endcase
				end
			end
			S_POP: begin
				pos_q <= hist_rd_q;
			end
			S_DOWN: begin
				if (!leaf) begin
					lo_lv_q[up_k] <= lo_q;
					hi_lv_q[up_k] <= hi_q;
					dir_lv_q[up_k] <= dir;
					node_q <= {node_q[NODE_AW-2:0], dir};
					if (dir) begin
						lo_q <= half_next;
					end else begin
						hi_q <= half;
					end
					lvl_q <= lvl_q + LVC_W'(1);
				end else begin
					cur_q <= leaf_word;
					lvl_q <= lvl_q - LVC_W'(1);
				end
			end
			S_UP: begin
				cur_q <= mrg_out;
				node_q <= node_q >> 1;
				lvl_q <= lvl_q - LVC_W'(1);
			end
			S_QROOT: begin
				cur_q <= resolve(rd_a_q, size);
			end
			S_QEVAL: begin
				if (q_done) begin
					run_q <= q_run;
				end else begin
					cur_q <= q_left ? qa : qb;
					node_q <= q_next_node;
					if (q_left) begin
						hi_q <= half;
					end else begin
						lo_q <= half_next;
					end
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_run_q <= run_q;
					out_status_q <= status_q;
				end
			end
			S_CLEAR: begin
			end
		endcase
	end

	// Node memory: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			tree_mem[mem_waddr] <= mem_wdata;
		end
		rd_a_q <= tree_mem[rd_addr_a];
		rd_b_q <= tree_mem[rd_addr_b];
	end

	// Removal history: pushed at the current count, read at the top entry.
	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[cnt_q[HIST_AW-1:0]] <= req.position;
		end
		hist_rd_q <= hist_mem[hist_raddr];
	end

	// Result channel.
	assign result.valid = out_valid_q;
	assign result.run_length = out_run_q;
	assign result.status = out_status_q;

	// The history count never passes the stack depth.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(HISTORY_DEPTH))
		else $error("history count above stack depth");

	// The walk down keeps the target position inside the current node.
	a_down_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DOWN |-> (pos_q >= lo_q) && (pos_q <= hi_q))
		else $error("update walk left the target position");

	// The walk down reaches a leaf within the tree height.
	a_down_depth: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DOWN |-> lvl_q <= LVC_W'(MAX_LEVELS))
		else $error("update walk deeper than the tree");

	// The walk up never climbs past the root.
	a_up_root: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UP |-> node_q > ROOT_NODE)
		else $error("update walk above the root");

	// A result is only loaded when a request has finished.
	a_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result loaded outside the finish state");

endmodule
